FILE: rtl/ekh_pkg.sv
// ----------------------------------------------------------------------------
// ekh_pkg: shared types and constants for the kernel density histogram
// Holds the action, status and register codes and the sequencer states.
// ----------------------------------------------------------------------------
package ekh_pkg;

	typedef enum logic [1:0] {
		ACT_CLEAR = 2'd0,
		ACT_ADD   = 2'd1,
		ACT_READ  = 2'd2,
		ACT_NONE  = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_SAMPLE_OR = 2'd1,
		ST_INDEX_OR  = 2'd2,
		ST_TOTAL_0   = 2'd3
	} status_t;

	localparam logic [1:0] REG_RANGE_LOW   = 2'd0;
	localparam logic [1:0] REG_BIN_SCALE   = 2'd1;
	localparam logic [1:0] REG_BINS_IN_USE = 2'd2;
	localparam logic [1:0] REG_HALF_WINDOW = 2'd3;

	localparam int BIN_W   = 40;
	localparam int TOTAL_W = 48;

	typedef enum logic [3:0] {
		S_IDLE,
		S_CLEAR,
		S_MUL,
		S_CHECK,
		S_RD,
		S_WR,
		S_RREAD,
		S_RWAIT,
		S_DIV,
		S_OUT
	} state_t;

endpackage

FILE: rtl/epanechnikov_kde_histogram.sv
// ----------------------------------------------------------------------------
// epanechnikov_kde_histogram: smoothed histogram with Epanechnikov weights
// Clears, adds kernel-weighted samples and reads bins as fractions of total.
// ----------------------------------------------------------------------------
// Channel   Dir   Contents
// s_axis    in    tdata: action[1:0], sample[33:2], bin_index[43:34]
// m_axis    out   tdata: status[1:0], density[33:2]
// cfg       in    cfg_we, cfg_idx, cfg_data
//
// One item is taken at a time; s_axis_tready is high only while idle.
// After reset a sweep zeroes the bin memory before the first beat. A clear runs the
// same sweep. An add finds the centre bin in S_MUL and S_CHECK, then updates each
// kernel bin applied (at most 2*h-1 bins) in S_RD and S_WR, skipping the centre's
// mirror and out-of-range bins. A read divides the bin by the total in the
// shift-subtract divider. The result beat is held until taken and blocks input.
module epanechnikov_kde_histogram #(
	parameter int BINS            = 1024,
	parameter int MAX_HALF_WINDOW = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [47:0] s_axis_tdata,   // action, sample, bin_index, zero fill
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [39:0] m_axis_tdata,   // status, density, zero fill
	input  logic        cfg_we,
	input  logic [1:0]  cfg_idx,
	input  logic [31:0] cfg_data
);
	localparam int AW = (BINS > 1) ? $clog2(BINS) : 1;
	localparam int HW = $clog2(MAX_HALF_WINDOW + 1);
	localparam int KW = HW + 1;
	localparam int BIN_MAX_W = ekh_pkg::BIN_W;
	localparam logic [BIN_MAX_W-1:0] BIN_MAX = '1;
	localparam logic [ekh_pkg::TOTAL_W-1:0] TOTAL_MAX = '1;
	localparam logic [AW:0] CLR_LAST = (AW + 1)'(BINS - 1);

	// Configuration registers.
	logic [31:0] range_low_q, bin_scale_q;
	logic [10:0] bins_in_use_q;
	logic [6:0]  half_window_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			range_low_q   <= '0;
			bin_scale_q   <= 32'd65536;
			bins_in_use_q <= 11'd1024;
			half_window_q <= 7'd20;
		end else if (cfg_we) begin
			case (cfg_idx)
				ekh_pkg::REG_RANGE_LOW:   range_low_q   <= cfg_data;
				ekh_pkg::REG_BIN_SCALE:   bin_scale_q   <= cfg_data;
				ekh_pkg::REG_BINS_IN_USE: bins_in_use_q <= cfg_data[10:0];
				ekh_pkg::REG_HALF_WINDOW: half_window_q <= cfg_data[6:0];
				default: ;
			endcase
		end
	end

	// Effective bin count and half window.
	logic [16:0] n_eff;
	logic [HW-1:0] h_eff;
	always_comb begin
		n_eff = (32'(bins_in_use_q) > 32'(BINS)) ? 17'(BINS) : 17'(bins_in_use_q);
		if (half_window_q == 7'd0) h_eff = HW'(1);
		else if (32'(half_window_q) > 32'(MAX_HALF_WINDOW)) h_eff = HW'(MAX_HALF_WINDOW);
		else h_eff = HW'(half_window_q);
	end

	ekh_pkg::state_t state_q, state_d;
	ekh_pkg::action_t act_q;
	logic [31:0] sample_q;
	logic [9:0]  index_q;
	logic [63:0] prod_q;
	logic [AW-1:0] centre_q, addr_q;
	logic [KW-1:0] k_q;
	logic          side_q;
	logic [2*HW-1:0] hh_q;
	logic [ekh_pkg::TOTAL_W-1:0] total_q;
	logic [1:0]  status_q;
	logic [31:0] density_q;
	logic [AW:0] clr_q;
	logic        boot_q;
	logic [BIN_MAX_W-1:0] rdata_q, wdata;
	logic [ekh_pkg::TOTAL_W:0] rem_q;
	logic [5:0] div_q;
	logic [BIN_MAX_W-1:0] mem [BINS];

	logic accept;
	assign accept = s_axis_tvalid && s_axis_tready;
	assign s_axis_tready = (state_q == ekh_pkg::S_IDLE);
	assign m_axis_tvalid = (state_q == ekh_pkg::S_OUT);
	assign m_axis_tdata  = {6'd0, density_q, status_q};

	// Current kernel weight and bin: weight hh-k*k on one side.
	logic [2*HW-1:0] wk;
	logic [17:0] cand;
	logic cand_ok, kdone;
	assign wk = hh_q - (2*HW)'(k_q * k_q);
	always_comb begin
		if (side_q) begin
			cand    = 18'(centre_q) - 18'(k_q);
			cand_ok = (18'(centre_q) >= 18'(k_q)) && (k_q != '0);
		end else begin
			cand    = 18'(centre_q) + 18'(k_q);
			cand_ok = cand < 18'(n_eff);
		end
		kdone = side_q && (32'(k_q) + 1 >= 32'(h_eff));
	end

	logic [BIN_MAX_W-1:0] cur;
	assign cur = rdata_q;
	always_comb begin
		logic [BIN_MAX_W:0] s;
		s = {1'b0, cur} + (BIN_MAX_W + 1)'(wk);
		wdata = s[BIN_MAX_W] ? BIN_MAX : s[BIN_MAX_W-1:0];
	end

	logic [ekh_pkg::TOTAL_W:0] rem_sh;
	assign rem_sh = {rem_q[ekh_pkg::TOTAL_W-1:0], 1'b0};
	logic [64:0] fi;
	assign fi = {1'b0, prod_q} + 65'(64'h8000_0000);

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ekh_pkg::S_IDLE: if (accept) begin
				case (ekh_pkg::action_t'(s_axis_tdata[1:0]))
					ekh_pkg::ACT_CLEAR: state_d = ekh_pkg::S_CLEAR;
					ekh_pkg::ACT_ADD:   state_d = ekh_pkg::S_MUL;
					ekh_pkg::ACT_READ:  state_d = ekh_pkg::S_RREAD;
					default:            state_d = ekh_pkg::S_OUT;
				endcase
			end
			ekh_pkg::S_CLEAR: begin
				if (clr_q == CLR_LAST)
					state_d = boot_q ? ekh_pkg::S_IDLE : ekh_pkg::S_OUT;
				else
					state_d = ekh_pkg::S_CLEAR;
			end
			ekh_pkg::S_MUL:   state_d = (sample_q < range_low_q) ? ekh_pkg::S_OUT
			                                                       : ekh_pkg::S_CHECK;
			ekh_pkg::S_CHECK: state_d = (fi[64:32] >= 33'(n_eff)) ? ekh_pkg::S_OUT
			                                                       : ekh_pkg::S_RD;
			ekh_pkg::S_RD:    state_d = cand_ok ? ekh_pkg::S_WR
			                            : (kdone ? ekh_pkg::S_OUT : ekh_pkg::S_RD);
			ekh_pkg::S_WR:    state_d = kdone ? ekh_pkg::S_OUT : ekh_pkg::S_RD;
			ekh_pkg::S_RREAD: begin
				if (17'(index_q) >= n_eff) state_d = ekh_pkg::S_OUT;
				else if (total_q == '0) state_d = ekh_pkg::S_OUT;
				else state_d = ekh_pkg::S_RWAIT;
			end
			ekh_pkg::S_RWAIT: state_d = ekh_pkg::S_DIV;
			ekh_pkg::S_DIV:   state_d = (div_q == 6'd32) ? ekh_pkg::S_OUT : ekh_pkg::S_DIV;
			ekh_pkg::S_OUT:   state_d = m_axis_tready ? ekh_pkg::S_IDLE : ekh_pkg::S_OUT;
			default:          state_d = ekh_pkg::S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ekh_pkg::S_CLEAR;
		else         state_q <= state_d;
	end

	// The first sweep after reset ends in idle without a result beat.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) boot_q <= 1'b1;
		else if (state_q == ekh_pkg::S_CLEAR && clr_q == CLR_LAST) boot_q <= 1'b0;
	end

	// Read address: kernel candidate, requested bin, or the bin being updated.
	logic [AW-1:0] rd_addr;
	always_comb begin
		case (state_q)
			ekh_pkg::S_RD:    rd_addr = cand[AW-1:0];
			ekh_pkg::S_RREAD: rd_addr = AW'(index_q);
			default:          rd_addr = addr_q;
		endcase
	end

	// Bin memory: one read and one write port, registered read.
	always_ff @(posedge clk) begin
		if (state_q == ekh_pkg::S_WR) mem[addr_q] <= wdata;
		else if (state_q == ekh_pkg::S_CLEAR) mem[clr_q[AW-1:0]] <= '0;
		rdata_q <= mem[rd_addr];
	end

	// Datapath under sequencer control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= '0;
			clr_q   <= '0;
		end else begin
			if (state_q == ekh_pkg::S_CLEAR) total_q <= '0;
			else if (state_q == ekh_pkg::S_WR) begin
				logic [ekh_pkg::TOTAL_W:0] t;
				t = {1'b0, total_q} + (ekh_pkg::TOTAL_W + 1)'(wk);
				total_q <= t[ekh_pkg::TOTAL_W] ? TOTAL_MAX : t[ekh_pkg::TOTAL_W-1:0];
			end
			if (state_q == ekh_pkg::S_CLEAR) clr_q <= clr_q + 1'b1;
			else clr_q <= '0;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ekh_pkg::S_IDLE: begin
				act_q     <= ekh_pkg::action_t'(s_axis_tdata[1:0]);
				sample_q  <= s_axis_tdata[33:2];
				index_q   <= s_axis_tdata[43:34];
				status_q  <= ekh_pkg::ST_OK;
				density_q <= '0;
				hh_q      <= (2*HW)'(h_eff * h_eff);
				k_q       <= '0;
				side_q    <= 1'b0;
			end
			ekh_pkg::S_MUL: begin
				prod_q <= 64'(sample_q - range_low_q) * 64'(bin_scale_q);
				if (sample_q < range_low_q) status_q <= ekh_pkg::ST_SAMPLE_OR;
			end
			ekh_pkg::S_CHECK: begin
				centre_q <= AW'(fi[63:32]);
				if (fi[64:32] >= 33'(n_eff)) status_q <= ekh_pkg::ST_SAMPLE_OR;
			end
			ekh_pkg::S_RD: begin
				addr_q <= cand[AW-1:0];
				if (!cand_ok) begin
					side_q <= ~side_q;
					if (side_q) k_q <= k_q + 1'b1;
				end
			end
			ekh_pkg::S_WR: begin
				side_q <= ~side_q;
				if (side_q) k_q <= k_q + 1'b1;
			end
			ekh_pkg::S_RREAD: begin
				addr_q <= AW'(index_q);
				div_q  <= '0;
				if (17'(index_q) >= n_eff) status_q <= ekh_pkg::ST_INDEX_OR;
				else if (total_q == '0) status_q <= ekh_pkg::ST_TOTAL_0;
			end
			ekh_pkg::S_RWAIT: begin
				rem_q <= (ekh_pkg::TOTAL_W + 1)'(cur);
				if ((ekh_pkg::TOTAL_W + 1)'(cur) >= {1'b0, total_q}) div_q <= 6'd32;
				density_q <= ((ekh_pkg::TOTAL_W + 1)'(cur) >= {1'b0, total_q}) ? '1 : '0;
			end
			ekh_pkg::S_DIV: if (div_q != 6'd32) begin
				div_q <= div_q + 1'b1;
				if (rem_sh >= {1'b0, total_q}) begin
					rem_q     <= rem_sh - {1'b0, total_q};
					density_q <= {density_q[30:0], 1'b1};
				end else begin
					rem_q     <= rem_sh;
					density_q <= {density_q[30:0], 1'b0};
				end
			end
			default: ;
		endcase
	end

	// Checks on the sequencer.
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ekh_pkg::S_IDLE) |-> !s_axis_tready) else $error("ready while busy");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
		else $error("result dropped");
	a_dens: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && status_q != ekh_pkg::ST_OK) |-> (density_q == '0))
		else $error("density on error");
	a_one: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !m_axis_tvalid || (act_q == ekh_pkg::ACT_NONE))
		else $error("early result");
endmodule

FILE: sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: testbench for the Epanechnikov kernel density histogram
// A table of directed beats followed by random traffic. Every result beat is
// checked against a known result or a behavioral histogram in the testbench.
// ----------------------------------------------------------------------------
module tb_top;

	localparam int NBINS = 1024;
	localparam int MAXH  = 64;
	localparam longint unsigned BINCAP = (64'd1 << 40) - 1;
	localparam longint unsigned TOTCAP = (64'd1 << 48) - 1;
	localparam longint LIMIT = 4000000;

	typedef struct packed {
		ekh_pkg::status_t status;
		logic [31:0]      density;
	} result_t;

	typedef struct {
		ekh_pkg::action_t act;
		logic [31:0]      sample;
		logic [9:0]       idx;
		logic             known;
		ekh_pkg::status_t st;
		logic [31:0]      dens;
	} row_t;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [47:0] s_axis_tdata;   // action[1:0], sample[33:2], bin_index[43:34]
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [39:0] m_axis_tdata;   // status[1:0], density[33:2]
	logic        cfg_we;
	logic [1:0]  cfg_idx;
	logic [31:0] cfg_data;

	epanechnikov_kde_histogram u_dut (.*);

	// Histogram shadow state and configuration.
	longint unsigned hist_bins [NBINS];
	longint unsigned hist_total;
	logic [31:0] r_low, r_scale;
	logic [10:0] r_bins;
	logic [6:0]  r_half;

	result_t pending_results[$];
	int  errors = 0;
	int  send_idle = 27, recv_idle = 74;
	bit  recv_hold = 0;
	longint cycles = 0;

	// Clock and reset.
	initial clk = 1'b0;
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	initial begin
		arst_n = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
	end

	// Watchdog.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("tb_top: FAIL");
			$finish;
		end
	end

	function automatic void sat_bin(int i, longint unsigned w);
		hist_bins[i] = (hist_bins[i] + w > BINCAP) ? BINCAP : hist_bins[i] + w;
		hist_total = (hist_total + w > TOTCAP) ? TOTCAP : hist_total + w;
	endfunction

	function automatic logic [31:0] fraction(longint unsigned num, longint unsigned den);
		longint unsigned rem;
		logic [31:0] q;
		rem = num;
		q = '0;
		if (rem >= den) return 32'hFFFF_FFFF;
		for (int i = 0; i < 32; i++) begin
			rem = rem << 1;
			q = q << 1;
			if (rem >= den) begin
				rem = rem - den;
				q[0] = 1'b1;
			end
		end
		return q;
	endfunction

	// Predict the result of one beat and update the shadow histogram.
	function automatic result_t histogram_step(ekh_pkg::action_t a, logic [31:0] smp,
		logic [9:0] bi);
		result_t r;
		int n, h, c;
		longint unsigned prod, fi, hh, w;
		r.status = ekh_pkg::ST_OK;
		r.density = '0;
		n = (r_bins > NBINS) ? NBINS : int'(r_bins);
		case (a)
			ekh_pkg::ACT_CLEAR: begin
				foreach (hist_bins[i]) hist_bins[i] = 0;
				hist_total = 0;
			end
			ekh_pkg::ACT_ADD: begin
				if (smp < r_low) r.status = ekh_pkg::ST_SAMPLE_OR;
				else begin
					prod = 64'(smp - r_low) * 64'(r_scale);
					fi = (prod + (64'd1 << 31)) >> 32;
					if (fi >= n) r.status = ekh_pkg::ST_SAMPLE_OR;
					else begin
						h = (r_half < 1) ? 1 : (r_half > MAXH ? MAXH : int'(r_half));
						c = int'(fi);
						hh = h * h;
						sat_bin(c, hh);
						for (int k = 1; k < h; k++) begin
							w = hh - k * k;
							if (c + k < n) sat_bin(c + k, w);
							if (c >= k) sat_bin(c - k, w);
						end
					end
				end
			end
			ekh_pkg::ACT_READ: begin
				if (bi >= n) r.status = ekh_pkg::ST_INDEX_OR;
				else if (hist_total == 0) r.status = ekh_pkg::ST_TOTAL_0;
				else r.density = fraction(hist_bins[bi], hist_total);
			end
			default: ;
		endcase
		return r;
	endfunction

	// Receiver: random stalls, plus a long hold-off when requested.
	initial begin
		m_axis_tready = 1'b0;
		forever begin
			@(posedge clk);
			if (recv_hold) m_axis_tready <= 1'b0;
			else m_axis_tready <= ($urandom_range(99) >= recv_idle);
		end
	end

	// Result checker.
	always @(posedge clk) begin
		result_t got, want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = {m_axis_tdata[1:0], m_axis_tdata[33:2]};
			if (pending_results.size() == 0) begin
				$error("result beat with no expectation: %h", got);
				errors++;
			end else begin
				want = pending_results.pop_front();
				if (got.status !== want.status) begin
					$error("status expected %0d actual %0d", want.status, got.status);
					errors++;
				end
				if (got.density !== want.density) begin
					$error("density expected %h actual %h", want.density, got.density);
					errors++;
				end
			end
		end
	end

	task automatic send_beat(ekh_pkg::action_t a, logic [31:0] smp, logic [9:0] bi,
		bit known = 0, ekh_pkg::status_t st = ekh_pkg::ST_OK, logic [31:0] dn = '0);
		result_t r;
		while (send_idle > 0 && $urandom_range(99) < send_idle) @(posedge clk);
		r = histogram_step(a, smp, bi);
		if (known) r = '{st, dn};
		pending_results.push_back(r);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {4'd0, bi, smp, a};
		do @(posedge clk); while (!s_axis_tready);
		s_axis_tvalid <= 1'b0;
		// The block is busy in the cycle after a beat, so this costs no rate.
		@(posedge clk);
	endtask

	task automatic drain();
		while (pending_results.size() != 0) @(posedge clk);
		repeat (300) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [31:0] val);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		case (idx)
			ekh_pkg::REG_RANGE_LOW:   r_low = val;
			ekh_pkg::REG_BIN_SCALE:   r_scale = val;
			ekh_pkg::REG_BINS_IN_USE: r_bins = val[10:0];
			ekh_pkg::REG_HALF_WINDOW: r_half = val[6:0];
			default: ;
		endcase
	endtask

	// Random sample biased toward landing in range.
	function automatic logic [31:0] pick_sample();
		int n;
		n = (r_bins > NBINS) ? NBINS : int'(r_bins);
		if ($urandom_range(9) == 0 || r_scale == 0) return $urandom;
		if (r_scale < 32'h100) return r_low + $urandom;
		return r_low + 32'(64'($urandom_range(n + 1)) * 65536 * 65536 / r_scale);
	endfunction

	task automatic random_run(int count);
		int p;
		for (int i = 0; i < count; i++) begin
			p = $urandom_range(99);
			if (p < 3) send_beat(ekh_pkg::ACT_CLEAR, $urandom, 10'($urandom));
			else if (p < 55) send_beat(ekh_pkg::ACT_ADD, pick_sample(), 10'($urandom));
			else if (p < 95) send_beat(ekh_pkg::ACT_READ, $urandom,
				$urandom_range(1) ? 10'($urandom_range(r_bins + 2)) : 10'($urandom));
			else send_beat(ekh_pkg::ACT_NONE, $urandom, 10'($urandom));
		end
	endtask

	row_t rows [$];

	initial begin
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		cfg_we = 1'b0;
		cfg_idx = '0;
		cfg_data = '0;
		r_low = '0;
		r_scale = 32'h10000;
		r_bins = 11'd1024;
		r_half = 7'd20;
		foreach (hist_bins[i]) hist_bins[i] = 0;
		hist_total = 0;
		@(posedge arst_n);
		@(posedge clk);

		// Directed table: known results where obvious, predictor otherwise.
		rows = '{
			'{ekh_pkg::ACT_READ,  32'h0,        10'd5,   1, ekh_pkg::ST_TOTAL_0,   32'h0},
			'{ekh_pkg::ACT_NONE,  32'hFFFFFFFF, 10'h3FF, 1, ekh_pkg::ST_OK,        32'h0},
			'{ekh_pkg::ACT_ADD,   32'hFFFFFFFF, 10'h0,   1, ekh_pkg::ST_SAMPLE_OR, 32'h0},
			'{ekh_pkg::ACT_ADD,   32'h0,        10'h0,   0, ekh_pkg::ST_OK,        32'h0},
			'{ekh_pkg::ACT_READ,  32'h0,        10'd0,   0, ekh_pkg::ST_OK,        32'h0},
			'{ekh_pkg::ACT_READ,  32'h0,        10'd19,  0, ekh_pkg::ST_OK,        32'h0},
			'{ekh_pkg::ACT_READ,  32'h0,        10'd20,  1, ekh_pkg::ST_OK,        32'h0},
			'{ekh_pkg::ACT_ADD,   32'h03FF8000, 10'h0,   0, ekh_pkg::ST_OK,        32'h0},
			'{ekh_pkg::ACT_ADD,   32'h03FF7FFF, 10'h0,   0, ekh_pkg::ST_OK,        32'h0},
			'{ekh_pkg::ACT_ADD,   32'h04000000, 10'h0,   1, ekh_pkg::ST_SAMPLE_OR, 32'h0},
			'{ekh_pkg::ACT_ADD,   32'h00208000, 10'h0,   0, ekh_pkg::ST_OK,        32'h0},
			'{ekh_pkg::ACT_READ,  32'hFFFFFFFF, 10'h3FF, 0, ekh_pkg::ST_OK,        32'h0},
			'{ekh_pkg::ACT_READ,  32'h0,        10'd32,  0, ekh_pkg::ST_OK,        32'h0},
			'{ekh_pkg::ACT_CLEAR, 32'hFFFFFFFF, 10'h3FF, 1, ekh_pkg::ST_OK,        32'h0},
			'{ekh_pkg::ACT_READ,  32'h0,        10'd0,   1, ekh_pkg::ST_TOTAL_0,   32'h0}
		};
		foreach (rows[i])
			send_beat(rows[i].act, rows[i].sample, rows[i].idx,
				rows[i].known, rows[i].st, rows[i].dens);
		drain();

		// Narrow histogram, half window one: a single bin gets everything.
		write_reg(ekh_pkg::REG_BINS_IN_USE, 32'd1);
		write_reg(ekh_pkg::REG_HALF_WINDOW, 32'd0);
		send_beat(ekh_pkg::ACT_ADD, 32'h0, 10'd0);
		send_beat(ekh_pkg::ACT_READ, 32'h0, 10'd0, 1, ekh_pkg::ST_OK, 32'hFFFFFFFF);
		send_beat(ekh_pkg::ACT_READ, 32'h0, 10'd1, 1, ekh_pkg::ST_INDEX_OR, 32'h0);
		drain();
		write_reg(ekh_pkg::REG_BINS_IN_USE, 32'd0);
		send_beat(ekh_pkg::ACT_ADD, 32'h0, 10'd0, 1, ekh_pkg::ST_SAMPLE_OR, 32'h0);
		send_beat(ekh_pkg::ACT_READ, 32'h0, 10'd0, 1, ekh_pkg::ST_INDEX_OR, 32'h0);
		drain();

		// Phase 1: default-ish setting, sender idles less than receiver.
		write_reg(ekh_pkg::REG_RANGE_LOW, 32'h00010000);
		write_reg(ekh_pkg::REG_BIN_SCALE, 32'h00020000);
		write_reg(ekh_pkg::REG_BINS_IN_USE, 32'h7FF);
		write_reg(ekh_pkg::REG_HALF_WINDOW, 32'd5);
		random_run(120);
		drain();

		// Long receiver hold-off while the sender keeps offering beats.
		fork
			begin
				recv_hold = 1;
				repeat (2000) @(posedge clk);
				recv_hold = 0;
			end
			random_run(10);
		join
		drain();

		// Phase 2: idling swapped, maximum window, small histogram.
		send_idle = 74;
		recv_idle = 27;
		write_reg(ekh_pkg::REG_RANGE_LOW, 32'hFFFF0000);
		write_reg(ekh_pkg::REG_BIN_SCALE, 32'hFFFFFFFF);
		write_reg(ekh_pkg::REG_BINS_IN_USE, 32'd40);
		write_reg(ekh_pkg::REG_HALF_WINDOW, 32'h7F);
		random_run(60);
		drain();
		write_reg(ekh_pkg::REG_RANGE_LOW, 32'd0);
		write_reg(ekh_pkg::REG_BIN_SCALE, 32'd1);
		write_reg(ekh_pkg::REG_HALF_WINDOW, 32'd64);
		random_run(60);
		drain();

		// Phase 3: no idling at all.
		send_idle = 0;
		recv_idle = 0;
		write_reg(ekh_pkg::REG_RANGE_LOW, 32'd0);
		write_reg(ekh_pkg::REG_BIN_SCALE, 32'h00400000);
		write_reg(ekh_pkg::REG_BINS_IN_USE, 32'd1024);
		write_reg(ekh_pkg::REG_HALF_WINDOW, 32'd3);
		random_run(150);
		drain();
		write_reg(ekh_pkg::REG_BIN_SCALE, 32'd0);
		write_reg(ekh_pkg::REG_BINS_IN_USE, 32'd2);
		random_run(40);
		drain();

		if (errors == 0 && pending_results.size() == 0) $display("tb_top: PASS");
		else $display("tb_top: FAIL");
		$finish;
	end
endmodule

FILE: filelist.f
rtl/ekh_pkg.sv
rtl/epanechnikov_kde_histogram.sv
sim/tb_top.sv
